// File: hw/rtl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants of the clamped PID controller
// Sequencer states, configuration register indexes and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

  // Width of a Q8.8 signal, gain or limit.
  localparam int unsigned DataW = 16;
  // Width of the integral accumulator, Q8.16.
  localparam int unsigned IntegW = 24;
  // Width of the configuration register index.
  localparam int unsigned CfgIdxW = 3;
  // Width that holds any supported update rate (1 to 1000).
  localparam int unsigned RateW = 10;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegGainProp  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGainInteg = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainDeriv = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOutMin    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOutMax    = 3'd4;

  typedef enum logic [3:0] {
    StIdle,
    StMulP,
    StMulI,
    StAbs,
    StDivEst,
    StDivMul,
    StDivFix,
    StIntAdd,
    StIntClamp,
    StSum,
    StFinish
  } pcc_state_e;

endpackage

`default_nettype wire

// File: hw/rtl/pid_controller_clamped_unit.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped_unit: clamped PID controller, Q8.8 fixed point
// Derivative on measurement, integral clamped to the output range.
// ----------------------------------------------------------------------------
// Usage:
//   Gains and limits are written through the cfg channel (index 0..4:
//   gain_prop, gain_integ, gain_deriv, out_min, out_max; other indexes are
//   ignored). cfg_ready_o is always high; write only while the block is idle.
//   An input item carries time_passed, setpoint and measured. Each item gives
//   exactly one drive item on the output channel.
//   A control step runs through the states StMulP to StSum and loads its
//   drive into the output register from StFinish; a hold item (time_passed
//   low) goes from idle straight to StFinish. A new item is taken only once
//   the sequencer is back in idle, so a hold item clears sooner than a step.
//   The control sequence is long because the single shared 33x33 multiplier
//   runs the three gain products, the derivative rate scaling and the
//   reciprocal division of the integral increment one after the other.
//   in_ready_o is high only while the sequencer is idle, so one item is in
//   work at a time. The output register lets the next item be accepted while
//   a drive waits; if the receiver stalls, the sequencer holds its finished
//   result until the output register is free.
//   Reset clears gains, limits, integral and previous measurement to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_clamped_unit #(
  parameter int unsigned UPDATE_RATE_HZ = 30
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // configuration
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire  [pcc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire  [pcc_pkg::DataW-1:0]         cfg_data_i,
  // input items
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire                               time_passed_i,
  input  wire  signed [pcc_pkg::DataW-1:0]  setpoint_i,
  input  wire  signed [pcc_pkg::DataW-1:0]  measured_i,
  // result items
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic signed [pcc_pkg::DataW-1:0]  drive_o
);

  import pcc_pkg::*;

  localparam logic [RateW-1:0] Rate = RateW'(UPDATE_RATE_HZ);
  // floor(2^31 / rate): the quotient estimate is at most one below the truth.
  localparam logic [32:0] Recip = 33'((64'd1 << 31) / UPDATE_RATE_HZ);

  // Configuration registers.
  logic signed [DataW-1:0] gain_prop_q, gain_integ_q, gain_deriv_q;
  logic signed [DataW-1:0] out_min_q, out_max_q;

  // Controller state.
  logic signed [IntegW-1:0] integ_q;
  logic signed [DataW-1:0]  prev_q;

  // Sequencer.
  pcc_state_e state_q, state_d;

  // Working registers.
  logic               hold_q;
  logic signed [16:0] err_q;
  logic signed [16:0] delta_q;
  logic signed [15:0] pv_q;
  logic signed [63:0] prod_q;
  logic signed [32:0] p_q;
  logic signed [27:0] dr_q;
  logic signed [43:0] d_q;
  logic        [30:0] m_q;
  logic               neg_q;
  logic        [30:0] q_q;
  logic signed [32:0] acc_q;
  logic signed [44:0] pd_q;
  logic signed [45:0] sum_q;

  // Output register.
  logic                    out_valid_q;
  logic signed [DataW-1:0] drive_q;

  // Shared multiplier.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_full;

  logic in_accept, out_free, out_load;

  // Combinational datapath values.
  logic signed [33:0] n_wide, m_wide;
  logic        [31:0] rem;
  logic signed [32:0] q_ext, integ_ext, lo33, hi33, acc_low;
  logic signed [32:0] integ_next;
  logic signed [45:0] lo46, hi46, clamped;
  logic signed [DataW-1:0] drive_d;

  assign cfg_ready_o = 1'b1;
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  // --------------------------------------------------------------------------
  // Configuration writes
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q  <= '0;
      gain_integ_q <= '0;
      gain_deriv_q <= '0;
      out_min_q    <= '0;
      out_max_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegGainProp:  gain_prop_q  <= cfg_data_i;
        RegGainInteg: gain_integ_q <= cfg_data_i;
        RegGainDeriv: gain_deriv_q <= cfg_data_i;
        RegOutMin:    out_min_q    <= cfg_data_i;
        RegOutMax:    out_max_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = time_passed_i ? StMulP : StFinish;
        end
      end
      StMulP:     state_d = StMulI;
      StMulI:     state_d = StAbs;
      StAbs:      state_d = StDivEst;
      StDivEst:   state_d = StDivMul;
      StDivMul:   state_d = StDivFix;
      StDivFix:   state_d = StIntAdd;
      StIntAdd:   state_d = StIntClamp;
      StIntClamp: state_d = StSum;
      StSum:      state_d = StFinish;
      StFinish: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default:    state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs (handshake and multiplier operand selection)
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
      end
      StMulP: begin
        mul_a = 33'(gain_prop_q);
        mul_b = 33'(err_q);
      end
      StMulI: begin
        mul_a = 33'(gain_integ_q);
        mul_b = 33'(err_q);
      end
      StAbs: begin
        mul_a = 33'(delta_q);
        mul_b = $signed({23'b0, Rate});
      end
      StDivEst: begin
        mul_a = $signed({2'b0, m_q});
        mul_b = $signed(Recip);
      end
      StDivMul: begin
        mul_a = $signed({2'b0, prod_q[61:31]});
        mul_b = $signed({23'b0, Rate});
      end
      StDivFix: begin
        mul_a = 33'(dr_q);
        mul_b = 33'(gain_deriv_q);
      end
      StFinish: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  always_comb begin
    // Floor division by the rate: a negative numerator is biased by rate-1 so
    // that truncating its magnitude rounds toward minus infinity.
    n_wide = 34'(prod_q[32:0]);
    m_wide = prod_q[32] ? ($signed({24'b0, Rate}) - 34'sd1 - n_wide) : n_wide;

    // Remainder of the quotient estimate; it lies below twice the rate.
    rem = {1'b0, m_q} - prod_q[31:0];

    q_ext     = $signed({2'b0, q_q});
    integ_ext = 33'(integ_q);
    lo33      = 33'($signed({out_min_q, 8'b0}));
    hi33      = 33'($signed({out_max_q, 8'b0}));

    // The integral is raised to the lower limit first, then lowered to the upper.
    acc_low    = (acc_q < lo33) ? lo33 : acc_q;
    integ_next = (acc_low > hi33) ? hi33 : acc_low;

    lo46 = 46'($signed({out_min_q, 8'b0}));
    hi46 = 46'($signed({out_max_q, 8'b0}));
    if (sum_q > hi46) begin
      clamped = hi46;
    end else if (sum_q < lo46) begin
      clamped = lo46;
    end else begin
      clamped = sum_q;
    end
    drive_d = hold_q ? '0 : clamped[23:8];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[63:0];
    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          hold_q  <= !time_passed_i;
          err_q   <= 17'(setpoint_i) - 17'(measured_i);
          delta_q <= 17'(measured_i) - 17'(prev_q);
          pv_q    <= measured_i;
        end
      end
      StMulI: begin
        p_q <= prod_q[32:0];
      end
      StAbs: begin
        neg_q <= prod_q[32];
        m_q   <= m_wide[30:0];
      end
      StDivEst: begin
        dr_q <= prod_q[27:0];
      end
      StDivMul: begin
        q_q <= prod_q[61:31];
      end
      StDivFix: begin
        q_q <= q_q + 31'(rem >= {22'b0, Rate});
      end
      StIntAdd: begin
        d_q   <= prod_q[43:0];
        acc_q <= neg_q ? (integ_ext - q_ext) : (integ_ext + q_ext);
      end
      StIntClamp: begin
        pd_q <= 45'(p_q) - 45'(d_q);
      end
      StSum: begin
        sum_q <= 46'(pd_q) + 46'(integ_q);
      end
      default: ;
    endcase
  end

  // Controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else if (state_q == StIntClamp) begin
      integ_q <= integ_next[IntegW-1:0];
      prev_q  <= pv_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      drive_q <= drive_d;
    end
  end

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the clamped PID controller
// Drives directed and random control and hold items through the valid/ready
// channels and checks each drive item against a cycle-free predictor that
// tracks gains, limits, integral and previous measurement.
// ----------------------------------------------------------------------------

module tb;
  import pcc_pkg::*;

  localparam int RateHz = 30;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 16;
  localparam int unsigned HoldLen = 200;
  localparam int unsigned RandPhases = 10;
  localparam int unsigned ItemsPerPhase = 115;

  // Indexes past the last register; writes to them must be dropped.
  localparam logic [CfgIdxW-1:0] RegSpare0 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSpare1 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare2 = 3'd7;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CfgIdxW-1:0]        cfg_index_i;
  logic [DataW-1:0]          cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic                      time_passed_i;
  logic signed [DataW-1:0]   setpoint_i;
  logic signed [DataW-1:0]   measured_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [DataW-1:0]   drive_o;

  pid_controller_clamped_unit #(
    .UPDATE_RATE_HZ(RateHz)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .time_passed_i(time_passed_i),
    .setpoint_i   (setpoint_i),
    .measured_i   (measured_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .drive_o      (drive_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Controller copy used for prediction.
  logic signed [DataW-1:0] kp_m, ki_m, kd_m, lo_m, hi_m;
  longint                  integ_m;
  longint                  prev_pv_m;

  logic signed [DataW-1:0] drive_q[$];
  int unsigned             fail_cnt;
  int unsigned             cycle_cnt;
  bit                      in_gaps;
  bit                      out_stalls;
  bit                      hold_req;

  function automatic longint floor_div(input longint num, input longint den);
    longint q;
    q = num / den;
    if ((num % den != 0) && ((num < 0) != (den < 0))) q = q - 1;
    return q;
  endfunction

  // Advances the controller copy by one item and returns the drive it gives.
  function automatic logic signed [DataW-1:0] pid_step(input bit tp,
                                                       input logic signed [DataW-1:0] sp,
                                                       input logic signed [DataW-1:0] pv);
    longint err, lo, hi, p_term, d_term, sum, drive;
    if (!tp) return '0;
    err = longint'(sp) - longint'(pv);
    lo = longint'(lo_m) * 256;
    hi = longint'(hi_m) * 256;
    p_term = longint'(kp_m) * err;
    integ_m = integ_m + floor_div(longint'(ki_m) * err, longint'(RateHz));
    // Raise first, then lower: with inverted limits the upper one wins.
    if (integ_m < lo) integ_m = lo;
    if (integ_m > hi) integ_m = hi;
    d_term = longint'(kd_m) * (longint'(pv) - prev_pv_m) * longint'(RateHz);
    prev_pv_m = longint'(pv);
    sum = p_term + integ_m - d_term;
    if (sum > hi) sum = hi;
    else if (sum < lo) sum = lo;
    drive = floor_div(sum, 256);
    return drive[DataW-1:0];
  endfunction

  task automatic send_item(input bit tp, input logic signed [DataW-1:0] sp,
                           input logic signed [DataW-1:0] pv);
    if (in_gaps) begin
      while ($urandom_range(99) < 37) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    time_passed_i <= tp;
    setpoint_i    <= sp;
    measured_i    <= pv;
    do @(posedge clk_i); while (!in_ready_o);
    drive_q.push_back(pid_step(tp, sp, pv));
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegGainProp:  kp_m = val;
      RegGainInteg: ki_m = val;
      RegGainDeriv: kd_m = val;
      RegOutMin:    lo_m = val;
      RegOutMax:    hi_m = val;
      default: ;
    endcase
  endtask

  // Waits until every drive item has come back and the sequencer has settled.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input logic signed [DataW-1:0] kp, input logic signed [DataW-1:0] ki,
                            input logic signed [DataW-1:0] kd, input logic signed [DataW-1:0] lo,
                            input logic signed [DataW-1:0] hi);
    wait_idle();
    write_reg(RegGainProp, kp);
    write_reg(RegGainInteg, ki);
    write_reg(RegGainDeriv, kd);
    write_reg(RegOutMin, lo);
    write_reg(RegOutMax, hi);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [DataW-1:0] rand_gain();
    if ($urandom_range(3) != 0) return DataW'($urandom_range(1023)) - 16'sd512;
    return DataW'($urandom);
  endfunction

  // Mostly the measurement tracks the setpoint; sometimes it jumps anywhere.
  task automatic send_random_item();
    logic signed [DataW-1:0] sp, pv;
    sp = ($urandom_range(1) == 0) ? DataW'($urandom) : DataW'($urandom_range(4095)) - 16'sd2048;
    if ($urandom_range(4) != 0) pv = sp + (DataW'($urandom_range(511)) - 16'sd256);
    else pv = DataW'($urandom);
    send_item($urandom_range(99) < 88, sp, pv);
  endtask

  task automatic test_reset_defaults();
    // Both limits are zero after reset, so every drive item is zero.
    send_item(1'b1, 16'sh7fff, 16'sh8000);
    send_item(1'b1, 16'sh8000, 16'sh7fff);
    send_item(1'b0, 16'sd100, 16'sd200);
    send_item(1'b1, 16'sd0, 16'sd0);
    send_item(1'b1, 16'sd1234, 16'sd1000);
  endtask

  task automatic test_directed_gains();
    set_config(16'sh0100, 16'sh0100, 16'sh0010, 16'sh8000, 16'sh7fff);
    send_item(1'b1, 16'sh0100, 16'sh0100);
    // A setpoint step moves only P and I; the derivative sees the measurement.
    send_item(1'b1, 16'sh0800, 16'sh0100);
    send_item(1'b1, 16'sh0800, 16'sh0200);
    send_item(1'b0, -16'sd1, -16'sd1);
    send_item(1'b1, 16'sh7fff, 16'sh8000);
    send_item(1'b1, 16'sh8000, 16'sh7fff);
    send_item(1'b1, -16'sd1, 16'sd0);
  endtask

  task automatic test_inverted_limits();
    set_config(16'sh0100, 16'sh0400, 16'sh0000, 16'sd100, -16'sd100);
    send_item(1'b1, 16'sh1000, 16'sh0000);
    send_item(1'b1, -16'sh1000, 16'sh0000);
    send_item(1'b1, 16'sd0, 16'sd0);
  endtask

  task automatic test_ignored_index();
    set_config(16'sh0080, 16'sh0040, 16'sh0020, -16'sh0800, 16'sh0800);
    @(posedge clk_i);
    write_reg(RegSpare0, 16'h7fff);
    write_reg(RegSpare1, 16'h8000);
    write_reg(RegSpare2, 16'h5555);
    cfg_valid_i <= 1'b0;
    send_item(1'b1, 16'sh0300, 16'sh0100);
    send_item(1'b1, 16'sh0300, -16'sh0100);
  endtask

  task automatic test_extreme_gains();
    set_config(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_item(1'b1, 16'sh7fff, 16'sh8000);
    send_item(1'b1, 16'sh8000, 16'sh7fff);
    set_config(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_item(1'b1, 16'sh0001, 16'shffff);
    send_item(1'b1, 16'sh8000, 16'sh8000);
  endtask

  task automatic test_backpressure();
    set_config(16'sh0040, 16'sh0020, 16'sh0004, -16'sh2000, 16'sh2000);
    in_gaps = 1'b0;
    out_stalls = 1'b0;
    hold_req = 1'b1;
    repeat (24) send_random_item();
  endtask

  task automatic test_random();
    logic signed [DataW-1:0] a, b;
    for (int phase = 0; phase < RandPhases; phase++) begin
      a = DataW'($urandom);
      b = DataW'($urandom);
      case ($urandom_range(4))
        0: begin a = 16'sh8000; b = 16'sh7fff; end
        1: ;  // may leave the limits inverted
        default: if (a > b) {a, b} = {b, a};
      endcase
      set_config(rand_gain(), rand_gain(), rand_gain(), a, b);
      // One phase runs without any idling on either side.
      in_gaps = (phase != 4);
      out_stalls = (phase != 4);
      repeat (ItemsPerPhase) send_random_item();
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready_i = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldLen) @(posedge clk_i);
      end else begin
        out_ready_i <= !out_stalls || ($urandom_range(99) >= 37);
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_drive
    logic signed [DataW-1:0] want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (drive_q.size() == 0) begin
        $error("drive: no item expected, got %0d", drive_o);
        fail_cnt++;
      end else begin
        want = drive_q.pop_front();
        if (drive_o !== want) begin
          $error("drive: expected %0d, actual %0d", want, drive_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[pid_controller_clamped_unit] ERROR");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    time_passed_i = 1'b0;
    setpoint_i    = '0;
    measured_i    = '0;
    kp_m = '0; ki_m = '0; kd_m = '0; lo_m = '0; hi_m = '0;
    integ_m   = 0;
    prev_pv_m = 0;
    fail_cnt  = 0;
    in_gaps    = 1'b1;
    out_stalls = 1'b1;
    hold_req   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_gains();
    test_inverted_limits();
    test_ignored_index();
    test_extreme_gains();
    test_backpressure();
    test_random();

    wait_idle();
    if (fail_cnt == 0) begin
      $display("[pid_controller_clamped_unit] OK");
    end else begin
      $display("[pid_controller_clamped_unit] ERROR");
    end
    $finish;
  end

endmodule
